@@ hdl/multilevel_cache_hierarchy_model_macros.svh @@
// Assertion macros for the cache hierarchy model.
`ifndef MULTILEVEL_CACHE_HIERARCHY_MODEL_MACROS_SVH
`define MULTILEVEL_CACHE_HIERARCHY_MODEL_MACROS_SVH
`ifndef NO_ASSERTIONS
`define MCHM_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);
`define MCHM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);
`else
`define MCHM_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg)
`define MCHM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

@@ hdl/mchm_pkg.sv @@
// Shared types and constants of the cache hierarchy model.
package mchm_pkg;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP
	} mchm_state_t;

	typedef logic [2:0] cfg_idx_t;

	localparam cfg_idx_t CFG_NUM_LEVELS  = 3'd0;
	localparam cfg_idx_t CFG_MEM_LATENCY = 3'd1;
	localparam cfg_idx_t CFG_LAT_L1      = 3'd2;
	localparam cfg_idx_t CFG_LAT_L2      = 3'd3;
	localparam cfg_idx_t CFG_LAT_L3      = 3'd4;
	localparam cfg_idx_t CFG_OFFSET_L1   = 3'd5;
	localparam cfg_idx_t CFG_OFFSET_L2   = 3'd6;
	localparam cfg_idx_t CFG_OFFSET_L3   = 3'd7;

	localparam int CFG_DATA_W = 10;
	localparam int CYC_W      = 11;
	localparam int TOTAL_W    = 48;
	localparam int CNT_W      = 32;
	localparam int NUM_CNT    = 6;

	localparam logic [1:0] RST_NUM_LEVELS  = 2'd3;
	localparam logic [9:0] RST_MEM_LATENCY = 10'd100;
	localparam logic [7:0] RST_LAT_L1      = 8'd1;
	localparam logic [7:0] RST_LAT_L2      = 8'd10;
	localparam logic [7:0] RST_LAT_L3      = 8'd30;
	localparam logic [3:0] RST_OFFSET_L1   = 4'd5;
	localparam logic [3:0] RST_OFFSET_L2   = 4'd5;
	localparam logic [3:0] RST_OFFSET_L3   = 4'd6;

	localparam logic [1:0] HIT_NONE = 2'd0;
	localparam logic [1:0] HIT_L1   = 2'd1;
	localparam logic [1:0] HIT_L2   = 2'd2;
	localparam logic [1:0] HIT_L3   = 2'd3;

endpackage

@@ hdl/mchm_tag_ram.sv @@
// Tag store of one cache level: one write port, one registered read port.
module mchm_tag_ram #(
	parameter int IW = 6,
	parameter int DW = 33
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [IW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data,
	input  logic          rd_en,
	input  logic [IW-1:0] rd_addr,
	output logic [DW-1:0] rd_data
);
	logic [DW-1:0] mem [(1 << IW)];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule

@@ hdl/multilevel_cache_hierarchy_model.sv @@
// Direct-mapped three-level cache hierarchy timing model, top level.
// Tag stores are read when an item is accepted; the result is registered when the lookup
// finishes, which waits while an earlier result has not been taken. A new item is taken
// only in the idle state, after the last lookup; fills are written back in the lookup state.
// Reset: config registers, counters and cycle total return to reset values; then a
// clearing pass walks all 2**max(index bits) indices (1024 by default) and drops all valid bits.
module multilevel_cache_hierarchy_model #(
	parameter int FIRST_INDEX_BITS  = 6,
	parameter int SECOND_INDEX_BITS = 8,
	parameter int THIRD_INDEX_BITS  = 10,
	parameter int ADDR_BITS         = 32,
	parameter int MAX_LEVELS        = 3
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  mchm_pkg::cfg_idx_t                   cfg_index,
	input  logic [mchm_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 is_write,
	input  logic [31:0]                          address,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [1:0]                           hit_level,
	output logic [mchm_pkg::CYC_W-1:0]           access_cycles,
	output logic [mchm_pkg::TOTAL_W-1:0]         total_cycles,
	output logic [31:0]                          hits_first,
	output logic [31:0]                          misses_first,
	output logic [31:0]                          hits_second,
	output logic [31:0]                          misses_second,
	output logic [31:0]                          hits_third,
	output logic [31:0]                          misses_third
);
	import mchm_pkg::*;
	`include "multilevel_cache_hierarchy_model_macros.svh"

	localparam int L1_IW  = (FIRST_INDEX_BITS > 0) ? FIRST_INDEX_BITS : 1;
	localparam int L2_IW  = (SECOND_INDEX_BITS > 0) ? SECOND_INDEX_BITS : 1;
	localparam int L3_IW  = (THIRD_INDEX_BITS > 0) ? THIRD_INDEX_BITS : 1;
	localparam int MAX12  = (L1_IW > L2_IW) ? L1_IW : L2_IW;
	localparam int CLR_W  = (MAX12 > L3_IW) ? MAX12 : L3_IW;
	localparam int TW     = ADDR_BITS + 1;
	localparam logic [ADDR_BITS-1:0] L1_MASK = ADDR_BITS'((64'(1) << FIRST_INDEX_BITS) - 64'(1));
	localparam logic [ADDR_BITS-1:0] L2_MASK = ADDR_BITS'((64'(1) << SECOND_INDEX_BITS) - 64'(1));
	localparam logic [ADDR_BITS-1:0] L3_MASK = ADDR_BITS'((64'(1) << THIRD_INDEX_BITS) - 64'(1));
	localparam logic [1:0] MAX_LV = 2'(MAX_LEVELS);

	mchm_state_t state_q, state_d;

	logic [1:0] num_levels_q;
	logic [9:0] mem_latency_q;
	logic [7:0] lat_l1_q, lat_l2_q, lat_l3_q;
	logic [3:0] offset_l1_q, offset_l2_q, offset_l3_q;

	logic [CLR_W-1:0] clr_q;
	logic             clr_done;

	logic                 wr_s1;
	logic [L1_IW-1:0]     l1_idx_s1, l1_idx;
	logic [L2_IW-1:0]     l2_idx_s1, l2_idx;
	logic [L3_IW-1:0]     l3_idx_s1, l3_idx;
	logic [ADDR_BITS-1:0] l1_tag_s1, l2_tag_s1, l3_tag_s1;
	logic [ADDR_BITS-1:0] l1_tag, l2_tag, l3_tag, addr_in;
	logic [TW-1:0]        l1_rd, l2_rd, l3_rd;

	logic             in_acc, done, fill;
	logic [1:0]       n_eff;
	logic             used1, used2;
	logic [2:0]       h;
	logic [CYC_W-1:0] cyc;
	logic [1:0]       hit_d;
	logic [NUM_CNT-1:0] bump;
	logic [CNT_W-1:0] cnt_q [NUM_CNT];
	logic [TOTAL_W:0] total_sum;
	logic             out_valid_q;
	logic [1:0]       hit_level_q;
	logic [CYC_W-1:0] access_cycles_q;
	logic [TOTAL_W-1:0] total_q;

	logic             ram_wr;
	logic [L1_IW-1:0] l1_wa;
	logic [L2_IW-1:0] l2_wa;
	logic [L3_IW-1:0] l3_wa;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_levels_q  <= RST_NUM_LEVELS;
			mem_latency_q <= RST_MEM_LATENCY;
			lat_l1_q      <= RST_LAT_L1;
			lat_l2_q      <= RST_LAT_L2;
			lat_l3_q      <= RST_LAT_L3;
			offset_l1_q   <= RST_OFFSET_L1;
			offset_l2_q   <= RST_OFFSET_L2;
			offset_l3_q   <= RST_OFFSET_L3;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_NUM_LEVELS:  num_levels_q  <= cfg_data[1:0];
				CFG_MEM_LATENCY: mem_latency_q <= cfg_data[9:0];
				CFG_LAT_L1:      lat_l1_q      <= cfg_data[7:0];
				CFG_LAT_L2:      lat_l2_q      <= cfg_data[7:0];
				CFG_LAT_L3:      lat_l3_q      <= cfg_data[7:0];
				CFG_OFFSET_L1:   offset_l1_q   <= cfg_data[3:0];
				CFG_OFFSET_L2:   offset_l2_q   <= cfg_data[3:0];
				CFG_OFFSET_L3:   offset_l3_q   <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// state machine
	assign clr_done = &clr_q;
	assign in_acc   = in_valid && in_ready;
	assign done     = (state_q == ST_LOOKUP) && (!out_valid_q || out_ready);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR:  if (clr_done) state_d = ST_IDLE;
			ST_IDLE:   if (in_valid) state_d = ST_LOOKUP;
			ST_LOOKUP: if (done) state_d = ST_IDLE;
			default:   state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: in_ready = 1'b1;
			default: in_ready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + CLR_W'(1);
			end
		end
	end

	// address split at accept
	always_comb begin
		addr_in = address[ADDR_BITS-1:0];
		l1_idx  = L1_IW'((addr_in >> offset_l1_q) & L1_MASK);
		l2_idx  = L2_IW'((addr_in >> offset_l2_q) & L2_MASK);
		l3_idx  = L3_IW'((addr_in >> offset_l3_q) & L3_MASK);
		l1_tag  = addr_in >> (6'(offset_l1_q) + 6'(FIRST_INDEX_BITS));
		l2_tag  = addr_in >> (6'(offset_l2_q) + 6'(SECOND_INDEX_BITS));
		l3_tag  = addr_in >> (6'(offset_l3_q) + 6'(THIRD_INDEX_BITS));
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			wr_s1     <= is_write;
			l1_idx_s1 <= l1_idx;
			l2_idx_s1 <= l2_idx;
			l3_idx_s1 <= l3_idx;
			l1_tag_s1 <= l1_tag;
			l2_tag_s1 <= l2_tag;
			l3_tag_s1 <= l3_tag;
		end
	end

	// tag stores, valid bit on top of each word
	assign ram_wr = (state_q == ST_CLEAR) || (done && fill);
	assign l1_wa  = (state_q == ST_CLEAR) ? clr_q[L1_IW-1:0] : l1_idx_s1;
	assign l2_wa  = (state_q == ST_CLEAR) ? clr_q[L2_IW-1:0] : l2_idx_s1;
	assign l3_wa  = (state_q == ST_CLEAR) ? clr_q[L3_IW-1:0] : l3_idx_s1;

	mchm_tag_ram #(.IW(L1_IW), .DW(TW)) u_l1_ram (
		.clk     (clk),
		.wr_en   (ram_wr),
		.wr_addr (l1_wa),
		.wr_data ({state_q != ST_CLEAR, l1_tag_s1}),
		.rd_en   (in_acc),
		.rd_addr (l1_idx),
		.rd_data (l1_rd)
	);

	mchm_tag_ram #(.IW(L2_IW), .DW(TW)) u_l2_ram (
		.clk     (clk),
		.wr_en   (ram_wr && (state_q == ST_CLEAR || used1)),
		.wr_addr (l2_wa),
		.wr_data ({state_q != ST_CLEAR, l2_tag_s1}),
		.rd_en   (in_acc),
		.rd_addr (l2_idx),
		.rd_data (l2_rd)
	);

	mchm_tag_ram #(.IW(L3_IW), .DW(TW)) u_l3_ram (
		.clk     (clk),
		.wr_en   (ram_wr && (state_q == ST_CLEAR || used2)),
		.wr_addr (l3_wa),
		.wr_data ({state_q != ST_CLEAR, l3_tag_s1}),
		.rd_en   (in_acc),
		.rd_addr (l3_idx),
		.rd_data (l3_rd)
	);

	// lookup
	always_comb begin
		n_eff = num_levels_q;
		if (n_eff == 2'd0) n_eff = 2'd1;
		if (n_eff > MAX_LV) n_eff = MAX_LV;
		used1 = n_eff >= 2'd2;
		used2 = n_eff >= 2'd3;
		h[0]  = l1_rd[TW-1] && (l1_rd[ADDR_BITS-1:0] == l1_tag_s1);
		h[1]  = used1 && l2_rd[TW-1] && (l2_rd[ADDR_BITS-1:0] == l2_tag_s1);
		h[2]  = used2 && l3_rd[TW-1] && (l3_rd[ADDR_BITS-1:0] == l3_tag_s1);
		fill  = ~|h;

		if (h[0])      hit_d = HIT_L1;
		else if (h[1]) hit_d = HIT_L2;
		else if (h[2]) hit_d = HIT_L3;
		else           hit_d = HIT_NONE;

		cyc = CYC_W'(lat_l1_q);
		if (!wr_s1) begin
			if (!h[0] && used1) cyc = cyc + CYC_W'(lat_l2_q);
			if (!h[0] && !h[1] && used2) cyc = cyc + CYC_W'(lat_l3_q);
			if (fill) cyc = cyc + CYC_W'(mem_latency_q);
		end else if (fill) begin
			if (used1) cyc = cyc + CYC_W'(lat_l2_q);
			if (used2) cyc = cyc + CYC_W'(lat_l3_q);
			cyc = cyc + CYC_W'(mem_latency_q);
		end

		bump[0] = !wr_s1 && h[0];
		bump[1] = !wr_s1 && !h[0];
		bump[2] = !wr_s1 && !h[0] && h[1];
		bump[3] = !wr_s1 && !h[0] && used1 && !h[1];
		bump[4] = !wr_s1 && !h[0] && !h[1] && h[2];
		bump[5] = !wr_s1 && !h[0] && !h[1] && used2 && !h[2];

		total_sum = {1'b0, total_q} + (TOTAL_W+1)'(cyc);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			total_q     <= '0;
			for (int i = 0; i < NUM_CNT; i++) begin
				cnt_q[i] <= '0;
			end
		end else begin
			if (done) begin
				out_valid_q <= 1'b1;
				total_q     <= total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
				for (int i = 0; i < NUM_CNT; i++) begin
					if (bump[i] && !(&cnt_q[i])) begin
						cnt_q[i] <= cnt_q[i] + CNT_W'(1);
					end
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			hit_level_q     <= hit_d;
			access_cycles_q <= cyc;
		end
	end

	assign out_valid     = out_valid_q;
	assign hit_level     = hit_level_q;
	assign access_cycles = access_cycles_q;
	assign total_cycles  = total_q;
	assign hits_first    = cnt_q[0];
	assign misses_first  = cnt_q[1];
	assign hits_second   = cnt_q[2];
	assign misses_second = cnt_q[3];
	assign hits_third    = cnt_q[4];
	assign misses_third  = cnt_q[5];

	`MCHM_ASSERT_NEXT(a_accept_lookup, clk, arst_n, in_acc, state_q == ST_LOOKUP, "accepted item did not start lookup")
	`MCHM_ASSERT_NEXT(a_done_valid, clk, arst_n, done, out_valid_q, "finished lookup left no result")
	`MCHM_ASSERT_SAME(a_clear_blocks, clk, arst_n, state_q == ST_CLEAR, !in_ready && !out_valid_q, "item taken during clearing pass")
	`MCHM_ASSERT_NEXT(a_wait_counters, clk, arst_n, out_valid_q && !out_ready, $stable(total_q) && $stable(cnt_q[1]), "counters moved while result waits")
endmodule
